@@ hw/rtl/keyed_idle_pool_manager_assert.svh @@
// Assertion macros for the RTL of the idle pool manager.
`ifndef KEYED_IDLE_POOL_MANAGER_ASSERT_SVH
`define KEYED_IDLE_POOL_MANAGER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KIPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KIPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KIPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define KIPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/kipm_pkg.sv @@
package kipm_pkg;
    localparam int IDLE_DEPTH = 32;
    localparam int HOST_SLOTS = 16;
    localparam int KEY_BITS   = 16;

    localparam int IAW = (IDLE_DEPTH > 1) ? $clog2(IDLE_DEPTH) : 1;
    localparam int IFW = $clog2(IDLE_DEPTH + 1);
    localparam int HAW = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
    localparam int HFW = $clog2(HOST_SLOTS + 1);
    localparam int SCW = (IFW > HFW) ? IFW : HFW;
    localparam int CW  = $clog2(IDLE_DEPTH + 2);
    localparam int TW  = $clog2(HOST_SLOTS * 255 + 1);

    typedef enum logic [2:0] {
        MODE_ACQUIRE = 3'd0,
        MODE_OPEN    = 3'd1,
        MODE_RELEASE = 3'd2,
        MODE_DROP    = 3'd3,
        MODE_SHUT    = 3'd4,
        MODE_QUERY   = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_OPEN_NEED = 3'd1,
        ST_AT_CAP    = 3'd2,
        ST_CLOSED    = 3'd3,
        ST_PARKED    = 3'd4,
        ST_DONE      = 3'd5,
        ST_TBL_FULL  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CFG_MAX_IN_FLIGHT = 2'd0,
        CFG_MAX_IDLE      = 2'd1,
        CFG_TIMEOUT       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  max_in_flight;
        logic [5:0]  max_idle;
        logic [31:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [31:0]         park_t;
        logic [7:0]          handle;
    } t_idle_ent;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [7:0]          cnt;
    } t_host_ent;
endpackage

@@ hw/rtl/kipm_ram.sv @@
module kipm_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/kipm_cfg.sv @@
module kipm_cfg import kipm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_in_flight <= 8'd8;
            r_cfg.max_idle      <= 6'd4;
            r_cfg.timeout       <= 32'd90000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_IN_FLIGHT: r_cfg.max_in_flight <= i_cfg_data[7:0];
                CFG_MAX_IDLE:      r_cfg.max_idle      <= i_cfg_data[5:0];
                CFG_TIMEOUT:       r_cfg.timeout       <= i_cfg_data;
                default: begin
                    // unknown index: drop the word
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
endmodule

@@ hw/rtl/keyed_idle_pool_manager.sv @@
// channel  direction  handshake               payload
// command  in         start & !busy           i_mode i_key i_handle i_healthy i_connected i_now_ms
// result   out        o_valid (one cycle)     o_status o_handle_res o_key_in_flight
//                                             o_total_in_flight o_last
// config   in         i_cfg_valid & o_cfg_ready  i_cfg_index i_cfg_data
//
// One command at a time; busy holds from the accepting edge until the final word is registered.
// A table scan reads one entry per cycle, then waits for the registered read data of the last
// entry. Query, open and unhealthy release scan only the host table; drop and shutdown also
// scan the idle table once, acquire and parking release twice; emptying a host slot adds a
// move step. The final word appears in the same cycle that busy falls.
// Reset is synchronous and empties both tables at once through their fill counts.
// Results come one per cycle at most; the receiver cannot stall them.
`include "keyed_idle_pool_manager_assert.svh"
module keyed_idle_pool_manager import kipm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_mode,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [7:0]          i_handle,
    input  logic                i_healthy,
    input  logic                i_connected,
    input  logic [31:0]         i_now_ms,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [7:0]          o_handle_res,
    output logic [7:0]          o_key_in_flight,
    output logic [11:0]         o_total_in_flight,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HSCAN = 7'b0000010,
        S_ISCAN = 7'b0000100,
        S_HUPD  = 7'b0001000,
        S_HMOV  = 7'b0010000,
        S_ICOMP = 7'b0100000,
        S_FINAL = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        HOP_NONE = 2'd0,
        HOP_ADD  = 2'd1,
        HOP_SUB  = 2'd2,
        HOP_CLR  = 2'd3
    } t_hop;

    t_cfg cfg;

    kipm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    t_state r_state, n_state;
    logic [2:0] r_mode, n_mode;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [7:0] r_hin, n_hin;
    logic r_healthy, n_healthy, r_conn, n_conn;
    logic [31:0] r_now, n_now;
    logic [IFW-1:0] r_idle_fill, n_idle_fill, r_w, n_w;
    logic [HFW-1:0] r_host_fill, n_host_fill;
    logic [TW-1:0] r_total, n_total;
    logic [SCW-1:0] r_i, n_i, r_di, n_di;
    logic r_dv, n_dv;
    logic r_hit, n_hit;
    logic [HAW-1:0] r_h, n_h;
    logic [7:0] r_hcnt, n_hcnt, r_kc, n_kc;
    logic r_fv, n_fv;
    logic [IAW-1:0] r_fi, n_fi;
    logic [7:0] r_fh, n_fh;
    logic r_reuse, n_reuse;
    t_hop r_hop, n_hop;
    t_status r_fstat, n_fstat;
    logic [7:0] r_fhandle, n_fhandle;
    logic r_drop0, n_drop0;
    logic [CW-1:0] r_cnt, n_cnt, r_nclose, n_nclose, r_nclosed, n_nclosed;
    logic r_ov, n_ov, r_olast, n_olast;
    t_status r_ostat, n_ostat;
    logic [7:0] r_ohandle, n_ohandle;

    logic           iw_en, ir_en, hw_en, hr_en;
    logic [IAW-1:0] iw_addr, ir_addr;
    logic [HAW-1:0] hw_addr, hr_addr;
    t_idle_ent      iw_data, ir_data;
    t_host_ent      hw_data, hr_data;
    logic [$bits(t_idle_ent)-1:0] ir_raw;
    logic [$bits(t_host_ent)-1:0] hr_raw;

    kipm_ram #(.W($bits(t_idle_ent)), .D(IDLE_DEPTH)) u_idle_ram (
        .i_clk   (i_clk),
        .i_we    (iw_en),
        .i_waddr (iw_addr),
        .i_wdata (iw_data),
        .i_re    (ir_en),
        .i_raddr (ir_addr),
        .o_rdata (ir_raw)
    );

    kipm_ram #(.W($bits(t_host_ent)), .D(HOST_SLOTS)) u_host_ram (
        .i_clk   (i_clk),
        .i_we    (hw_en),
        .i_waddr (hw_addr),
        .i_wdata (hw_data),
        .i_re    (hr_en),
        .i_raddr (hr_addr),
        .o_rdata (hr_raw)
    );

    assign ir_data = t_idle_ent'(ir_raw);
    assign hr_data = t_host_ent'(hr_raw);

    logic        lim_ok;
    logic        scan_done;
    logic        expired;
    logic        kmatch;
    logic        is0;
    logic        after_host;
    logic        host_full;
    logic [31:0] c1;
    logic [7:0]  cnt_eff;
    logic [7:0]  newc;

    always_comb begin
        n_state = r_state;   n_mode = r_mode;     n_key = r_key;
        n_hin = r_hin;       n_healthy = r_healthy; n_conn = r_conn;
        n_now = r_now;       n_idle_fill = r_idle_fill; n_w = r_w;
        n_host_fill = r_host_fill; n_total = r_total;
        n_i = r_i;           n_di = r_di;         n_dv = 1'b0;
        n_hit = r_hit;       n_h = r_h;           n_hcnt = r_hcnt;  n_kc = r_kc;
        n_fv = r_fv;         n_fi = r_fi;         n_fh = r_fh;      n_reuse = r_reuse;
        n_hop = r_hop;       n_fstat = r_fstat;   n_fhandle = r_fhandle;
        n_drop0 = r_drop0;   n_cnt = r_cnt;       n_nclose = r_nclose;
        n_nclosed = r_nclosed;
        n_ov = 1'b0;         n_olast = 1'b0;      n_ostat = r_ostat;
        n_ohandle = r_ohandle;
        iw_en = 1'b0; iw_addr = r_w[IAW-1:0]; iw_data = '0;
        ir_en = 1'b0; ir_addr = r_i[IAW-1:0];
        hw_en = 1'b0; hw_addr = r_h; hw_data = '0;
        hr_en = 1'b0; hr_addr = r_i[HAW-1:0];
        after_host = 1'b0;
        host_full = (r_host_fill == HFW'(HOST_SLOTS));
        expired = ((r_now - ir_data.park_t) > cfg.timeout);
        kmatch  = (ir_data.key == r_key);
        is0     = (r_di == '0);
        c1 = 32'(r_cnt) + 32'd1;
        cnt_eff = r_hit ? r_hcnt : 8'd0;
        newc = r_hcnt - 8'd1;
        lim_ok = 1'b0;
        scan_done = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode = i_mode; n_key = i_key; n_hin = i_handle;
                    n_healthy = i_healthy; n_conn = i_connected; n_now = i_now_ms;
                    n_i = '0; n_hit = 1'b0; n_h = '0; n_hcnt = '0;
                    n_fhandle = '0; n_fstat = ST_DONE; n_hop = HOP_NONE;
                    n_reuse = 1'b0; n_fv = 1'b0;
                    n_state = S_HSCAN;
                end
            end
            S_HSCAN: begin
                lim_ok = (r_i < SCW'(r_host_fill));
                hr_en = lim_ok;
                n_dv = lim_ok;
                n_di = r_i;
                if (lim_ok) n_i = r_i + 1'b1;
                if (r_dv && !r_hit && hr_data.key == r_key) begin
                    n_hit = 1'b1; n_h = r_di[HAW-1:0]; n_hcnt = hr_data.cnt;
                end
                scan_done = !lim_ok && !r_dv;
                if (scan_done) begin
                    n_kc = cnt_eff;
                    n_i = '0;
                    n_state = S_HUPD;
                    case (r_mode)
                        MODE_ACQUIRE: n_state = S_ISCAN;
                        MODE_OPEN: begin
                            if (r_healthy) begin
                                if (!r_hit && host_full) n_fstat = ST_TBL_FULL;
                                else n_hop = HOP_ADD;
                            end
                        end
                        MODE_RELEASE: if (r_hit) n_hop = HOP_SUB;
                        MODE_SHUT: n_hop = HOP_CLR;
                        default: n_hop = HOP_NONE;
                    endcase
                end
            end
            S_ISCAN: begin
                lim_ok = (r_i < SCW'(r_idle_fill));
                ir_en = lim_ok;
                n_dv = lim_ok;
                n_di = r_i;
                if (lim_ok) n_i = r_i + 1'b1;
                if (r_dv) begin
                    if (r_mode == MODE_ACQUIRE) begin
                        if (!expired && kmatch) begin
                            n_fv = 1'b1; n_fi = r_di[IAW-1:0]; n_fh = ir_data.handle;
                        end
                    end else if (kmatch && !(r_drop0 && is0)) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                scan_done = !lim_ok && !r_dv;
                if (scan_done) begin
                    n_i = '0; n_w = '0; n_nclosed = '0;
                    if (r_mode == MODE_ACQUIRE) begin
                        n_state = S_HUPD;
                        if (r_fv) begin
                            if (!r_hit && host_full) begin
                                n_fstat = ST_TBL_FULL;
                            end else begin
                                n_reuse = 1'b1; n_fstat = ST_REUSED;
                                n_fhandle = r_fh; n_hop = HOP_ADD;
                            end
                        end else if (cnt_eff >= cfg.max_in_flight) begin
                            n_fstat = ST_AT_CAP;
                        end else begin
                            n_fstat = ST_OPEN_NEED;
                        end
                    end else begin
                        n_nclose = (c1 > 32'(cfg.max_idle)) ?
                                   CW'(c1 - 32'(cfg.max_idle)) : '0;
                        n_state = S_ICOMP;
                    end
                end
            end
            S_HUPD: begin
                after_host = 1'b1;
                case (r_hop)
                    HOP_ADD: begin
                        if (r_hit) begin
                            if (r_hcnt != 8'd255) begin
                                hw_en = 1'b1; hw_addr = r_h;
                                hw_data = '{key: r_key, cnt: r_hcnt + 8'd1};
                                n_kc = r_hcnt + 8'd1;
                                n_total = r_total + 1'b1;
                            end
                        end else begin
                            hw_en = 1'b1; hw_addr = r_host_fill[HAW-1:0];
                            hw_data = '{key: r_key, cnt: 8'd1};
                            n_host_fill = r_host_fill + 1'b1;
                            n_kc = 8'd1;
                            n_total = r_total + 1'b1;
                        end
                    end
                    HOP_SUB: begin
                        n_total = r_total - 1'b1;
                        n_kc = newc;
                        if (newc != 8'd0) begin
                            hw_en = 1'b1; hw_addr = r_h;
                            hw_data = '{key: r_key, cnt: newc};
                        end else begin
                            // fetch the last slot to fill the hole
                            hr_en = 1'b1;
                            hr_addr = HAW'(r_host_fill - 1'b1);
                            after_host = 1'b0;
                            n_state = S_HMOV;
                        end
                    end
                    HOP_CLR: begin
                        n_host_fill = '0; n_total = '0; n_kc = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_HMOV: begin
                hw_en = 1'b1; hw_addr = r_h; hw_data = hr_data;
                n_host_fill = r_host_fill - 1'b1;
                after_host = 1'b1;
            end
            S_ICOMP: begin
                lim_ok = (r_i < SCW'(r_idle_fill));
                ir_en = lim_ok;
                n_dv = lim_ok;
                n_di = r_i;
                if (lim_ok) n_i = r_i + 1'b1;
                if (r_dv) begin
                    if (r_mode == MODE_ACQUIRE) begin
                        if (expired) begin
                            n_ov = 1'b1;
                        end else if (!(r_reuse && r_di[IAW-1:0] == r_fi)) begin
                            iw_en = 1'b1;
                        end
                    end else if (r_mode == MODE_RELEASE) begin
                        if (r_drop0 && is0) begin
                            n_ov = 1'b1;
                        end else if (kmatch && r_nclosed < r_nclose) begin
                            n_ov = 1'b1;
                            n_nclosed = r_nclosed + 1'b1;
                        end else begin
                            iw_en = 1'b1;
                        end
                    end else begin
                        n_ov = 1'b1;
                    end
                    iw_data = ir_data;
                    if (iw_en) n_w = r_w + 1'b1;
                    n_ostat = ST_CLOSED;
                    n_ohandle = ir_data.handle;
                end
                scan_done = !lim_ok && !r_dv;
                if (scan_done) begin
                    n_idle_fill = r_w;
                    n_state = S_FINAL;
                    if (r_mode == MODE_RELEASE) begin
                        n_fhandle = r_hin;
                        if (r_nclosed < r_nclose) begin
                            n_fstat = ST_CLOSED;
                        end else begin
                            iw_en = 1'b1;
                            iw_data = '{key: r_key, park_t: r_now, handle: r_hin};
                            n_idle_fill = r_w + 1'b1;
                            n_fstat = ST_PARKED;
                        end
                    end
                end
            end
            S_FINAL: begin
                n_ov = 1'b1; n_olast = 1'b1;
                n_ostat = r_fstat; n_ohandle = r_fhandle;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (after_host) begin
            n_i = '0; n_w = '0; n_nclosed = '0;
            case (r_mode)
                MODE_ACQUIRE, MODE_DROP, MODE_SHUT: n_state = S_ICOMP;
                MODE_RELEASE: begin
                    if (!r_healthy || !r_conn) begin
                        n_fstat = ST_CLOSED; n_fhandle = r_hin;
                        n_state = S_FINAL;
                    end else begin
                        n_cnt = '0;
                        n_drop0 = (r_idle_fill == IFW'(IDLE_DEPTH));
                        n_state = S_ISCAN;
                    end
                end
                default: n_state = S_FINAL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idle_fill <= '0;
            r_host_fill <= '0;
            r_total <= '0;
            r_dv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idle_fill <= n_idle_fill;
            r_host_fill <= n_host_fill;
            r_total <= n_total;
            r_dv <= n_dv;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;       r_key <= n_key;       r_hin <= n_hin;
        r_healthy <= n_healthy; r_conn <= n_conn;     r_now <= n_now;
        r_w <= n_w;             r_i <= n_i;           r_di <= n_di;
        r_hit <= n_hit;         r_h <= n_h;           r_hcnt <= n_hcnt;
        r_kc <= n_kc;           r_fv <= n_fv;         r_fi <= n_fi;
        r_fh <= n_fh;           r_reuse <= n_reuse;   r_hop <= n_hop;
        r_fstat <= n_fstat;     r_fhandle <= n_fhandle;
        r_drop0 <= n_drop0;     r_cnt <= n_cnt;       r_nclose <= n_nclose;
        r_nclosed <= n_nclosed; r_olast <= n_olast;   r_ostat <= n_ostat;
        r_ohandle <= n_ohandle;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_ov;
    assign o_status          = r_ostat;
    assign o_handle_res      = r_ohandle;
    assign o_key_in_flight   = r_kc;
    assign o_total_in_flight = (32'(r_total) > 32'd4095) ? 12'd4095 : 12'(r_total);
    assign o_last            = r_olast;

    `KIPM_ASSERT(a_idle_fill_cap, i_clk, i_rst_n, r_idle_fill <= IFW'(IDLE_DEPTH), "idle fill over depth")
    `KIPM_ASSERT(a_host_fill_cap, i_clk, i_rst_n, r_host_fill <= HFW'(HOST_SLOTS), "host fill over slots")
    `KIPM_ASSERT(a_last_ends, i_clk, i_rst_n, (r_ov && r_olast) |=> !r_ov, "word after final result")
    `KIPM_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "command accepted but not busy")
    `KIPM_ASSERT(a_valid_in_work, i_clk, i_rst_n, r_ov |-> ($past(r_state) == S_ICOMP || $past(r_state) == S_FINAL), "result outside emit states")
endmodule
